>>> src/gcra_pkg.sv
// Shared constants, types and helpers for the GCRA multi-rule rate limiter.
// Depends on nothing; imported by gcra_multi_rule_rate_limiter.
package gcra_pkg;

  // Rule and bucket geometry. BUCKETS must be a power of two so that the
  // bucket number is the low bits of the hashed index.
  localparam int RULES     = 4;
  localparam int BUCKETS   = 16384;
  localparam int RULE_W    = 2;
  localparam int BKT_W     = $clog2(BUCKETS);
  localparam int ADDR_W    = RULE_W + BKT_W;
  localparam int MEM_DEPTH = RULES * BUCKETS;

  // Field widths.
  localparam int TIME_W     = 64;
  localparam int MASK_W     = 4;
  localparam int IDX_W      = 14;
  localparam int INTERVAL_W = 30;
  localparam int TOL_W      = 50;

  // Word packing on the streams.
  localparam int MASK_LSB   = TIME_W;
  localparam int IDX_LSB    = TIME_W + MASK_W;
  localparam int IN_DATA_W  = 128;
  localparam int OUT_DATA_W = 8;

  // Configuration port and register indexes.
  localparam int CFG_INDEX_W = 8;
  localparam int CFG_DATA_W  = 64;
  localparam int CFG_INTERVAL_0  = 0;
  localparam int CFG_TOLERANCE_0 = RULES;
  localparam int NUM_CFG         = 2 * RULES;

  // Controller states.
  typedef enum logic [5:0] {
    ST_CLEAR = 6'b000001,
    ST_IDLE  = 6'b000010,
    ST_READ  = 6'b000100,
    ST_EVAL  = 6'b001000,
    ST_CHECK = 6'b010000,
    ST_RESP  = 6'b100000
  } state_t;

  // Lowest applying rule of a nonzero mask.
  function automatic logic [RULE_W-1:0] first_rule(input logic [RULES-1:0] mask);
    logic [RULE_W-1:0] sel;
    sel = '0;
    for (int i = RULES - 1; i >= 0; i--) begin
      if (mask[i]) begin
        sel = RULE_W'(i);
      end
    end
    return sel;
  endfunction

endpackage

>>> src/gcra_multi_rule_rate_limiter.sv
// GCRA multi-rule rate limiter: policer walk over a single table of
// theoretical arrival times held in one synchronous memory.
// Depends on gcra_pkg.
//
//   Channel | Direction | Handshake              | Word
//   in_     | slave     | in_tvalid / in_tready  | time, rule mask, four bucket indexes
//   out_    | master    | out_tvalid / out_tready| allowed, rejecting rule
//   cfg_    | slave     | cfg_valid / cfg_ready  | register index and value
//
// A request passes the idle and response states and, for each applying rule
// visited, the read, evaluate and check states (read, evaluate, check and
// write back of one memory entry). The walk stops at the first rejection.
// After reset a clearing pass writes zero to all 65536 entries, one per
// cycle, while in_tready stays low; configuration writes are taken always.
// in_tready is high only between requests; a finished word waits in the
// output register while the next request is taken.
module gcra_multi_rule_rate_limiter
  import gcra_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  // Fields from bit 0: time_now[63:0], rule_mask[67:64], bucket_index_0[81:68],
  // bucket_index_1[95:82], bucket_index_2[109:96], bucket_index_3[123:110], zeros
  input  logic [IN_DATA_W-1:0]   in_tdata,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  // Fields from bit 0: allowed[0], reject_rule[2:1], zeros
  output logic [OUT_DATA_W-1:0]  out_tdata,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  input  logic                   cfg_valid,
  output logic                   cfg_ready
);

  state_t state_r, state_nxt;

  logic [ADDR_W-1:0]     clr_addr_r;
  logic [TIME_W-1:0]     now_r;
  logic [RULES-1:0]      mask_r;
  logic [BKT_W-1:0]      bkt_r [RULES];
  logic [RULE_W-1:0]     rule_r;
  logic [ADDR_W-1:0]     addr_r;
  logic [TIME_W-1:0]     rdata_r;
  logic                  late_r;
  logic [TIME_W-1:0]     diff_r;
  logic [TIME_W-1:0]     base_r;
  logic                  res_allowed_r;
  logic [RULE_W-1:0]     res_rule_r;
  logic                  out_valid_r;
  logic [OUT_DATA_W-1:0] out_data_r;
  logic [INTERVAL_W-1:0] interval_r [RULES];
  logic [TOL_W-1:0]      tolerance_r [RULES];

  logic [TIME_W-1:0] tat_mem [MEM_DEPTH];

  logic                  in_accept;
  logic [RULE_W-1:0]     next_rule;
  logic [ADDR_W-1:0]     rd_addr;
  logic [RULES-1:0]      rule_bit;
  logic                  over_tol;
  logic [TIME_W:0]       charge_sum;
  logic                  reject;
  logic                  out_load;
  logic                  mem_we;
  logic [ADDR_W-1:0]     mem_waddr;
  logic [TIME_W-1:0]     mem_wdata;

  assign in_tready  = (state_r == ST_IDLE);
  assign in_accept  = in_tvalid && in_tready;
  assign cfg_ready  = 1'b1;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // Address of the next applying rule's bucket.
  assign next_rule = first_rule(mask_r);
  assign rd_addr   = {next_rule, bkt_r[next_rule]};
  assign rule_bit  = RULES'(1) << rule_r;

  // Policing decision for the rule under check.
  assign over_tol   = late_r && (diff_r > {{(TIME_W-TOL_W){1'b0}}, tolerance_r[rule_r]});
  assign charge_sum = {1'b0, base_r} + {{(TIME_W-INTERVAL_W+1){1'b0}}, interval_r[rule_r]};
  assign reject     = over_tol || charge_sum[TIME_W];

  // The output register takes the result once it is free or being drained.
  assign out_load = (state_r == ST_RESP) && (!out_valid_r || out_tready);

  // Single write port: clearing pass or charge of an accepting rule.
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = addr_r;
    mem_wdata = charge_sum[TIME_W-1:0];
    if (state_r == ST_CLEAR) begin
      mem_we    = 1'b1;
      mem_waddr = clr_addr_r;
      mem_wdata = '0;
    end else if (state_r == ST_CHECK && !reject) begin
      mem_we = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      tat_mem[mem_waddr] <= mem_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_READ) begin
      rdata_r <= tat_mem[rd_addr];
    end
  end

  // Controller.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_CLEAR: begin
        if (clr_addr_r == ADDR_W'(MEM_DEPTH - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_accept) begin
          state_nxt = (in_tdata[MASK_LSB +: RULES] == '0) ? ST_RESP : ST_READ;
        end
      end
      ST_READ:  state_nxt = ST_EVAL;
      ST_EVAL:  state_nxt = ST_CHECK;
      ST_CHECK: begin
        if (reject || (mask_r & ~rule_bit) == '0) begin
          state_nxt = ST_RESP;
        end else begin
          state_nxt = ST_READ;
        end
      end
      ST_RESP: begin
        if (out_load) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_addr_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == ST_CLEAR) begin
        clr_addr_r <= clr_addr_r + ADDR_W'(1);
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Request fields, walk state and per-rule arithmetic.
  always_ff @(posedge clk) begin
    if (in_accept) begin
      now_r         <= in_tdata[TIME_W-1:0];
      mask_r        <= in_tdata[MASK_LSB +: RULES];
      res_allowed_r <= 1'b1;
      res_rule_r    <= '0;
      for (int i = 0; i < RULES; i++) begin
        bkt_r[i] <= in_tdata[IDX_LSB + i*IDX_W +: BKT_W];
      end
    end
    if (state_r == ST_READ) begin
      rule_r <= next_rule;
      addr_r <= rd_addr;
    end
    if (state_r == ST_EVAL) begin
      late_r <= (rdata_r > now_r);
      diff_r <= rdata_r - now_r;
      base_r <= (rdata_r > now_r) ? rdata_r : now_r;
    end
    if (state_r == ST_CHECK) begin
      mask_r <= mask_r & ~rule_bit;
      if (reject) begin
        res_allowed_r <= 1'b0;
        res_rule_r    <= rule_r;
      end
    end
    if (out_load) begin
      out_data_r <= {{(OUT_DATA_W-RULE_W-1){1'b0}}, res_rule_r, res_allowed_r};
    end
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < RULES; i++) begin
        interval_r[i]  <= INTERVAL_W'(1);
        tolerance_r[i] <= '0;
      end
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index < CFG_INDEX_W'(CFG_TOLERANCE_0)) begin
        interval_r[RULE_W'(cfg_index - CFG_INDEX_W'(CFG_INTERVAL_0))] <=
          cfg_data[INTERVAL_W-1:0];
      end else if (cfg_index < CFG_INDEX_W'(NUM_CFG)) begin
        tolerance_r[RULE_W'(cfg_index - CFG_INDEX_W'(CFG_TOLERANCE_0))] <=
          cfg_data[TOL_W-1:0];
      end
    end
  end

  // An accepted request always starts a walk or a response.
  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept |=> (state_r == ST_READ || state_r == ST_RESP))
    else $error("accepted request did not leave idle");

  // The rule being evaluated still has its mask bit set.
  a_eval_rule_pending: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_EVAL) |-> mask_r[rule_r])
    else $error("evaluating a rule that is not pending");

  // A rejection ends the walk with a deny result.
  a_reject_ends_walk: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_CHECK && reject) |=> (state_r == ST_RESP && !res_allowed_r))
    else $error("rejection did not end the walk");

  // A new output word only comes from the response state.
  a_out_from_resp: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == ST_RESP)
    else $error("output word raised outside response");

  // The table is written only by the clearing pass or a charge.
  a_write_source: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |-> (state_r == ST_CLEAR || state_r == ST_CHECK))
    else $error("table written outside clear or check");

endmodule
